@@ sv/usart_pkg.sv @@
// Package for the UART register block: register offsets, bit positions,
// command codes, receive FIFO sizing and the result record.
// Depends on nothing; used by usart_regs_with_rx_fifo.
`default_nettype none

package usart_pkg;

    // Receive FIFO sizing
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Item commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_HOST  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // Register offsets
    localparam logic [9:0] OFF_SR  = 10'h000;
    localparam logic [9:0] OFF_DR  = 10'h004;
    localparam logic [9:0] OFF_BRR = 10'h008;
    localparam logic [9:0] OFF_CR1 = 10'h00C;
    localparam logic [9:0] OFF_CR2 = 10'h010;
    localparam logic [9:0] OFF_CR3 = 10'h014;

    // Status bits
    localparam int ST_RXNE = 5;
    localparam int ST_TC   = 6;
    localparam int ST_TXE  = 7;

    // Ctrl1 bits
    localparam int C1_RE = 2;
    localparam int C1_TE = 3;
    localparam int C1_UE = 13;

    typedef struct packed {
        logic [31:0] rdata;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        rx_dropped;
    } t_result;

    // Ring pointer advance with wrap at the FIFO depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

@@ sv/usart_regs_with_rx_fifo.sv @@
// UART register block with receive FIFO: register file, ring FIFO memory
// and a two-slot result queue. Depends on usart_pkg.
//
// Usage:
//   Request channel (i_valid/o_ready): i_cmd selects bus read, bus write,
//   arriving host byte or poll tick; i_offset/i_wdata qualify bus accesses,
//   i_rx_byte carries the host byte. Response channel (o_valid/i_ready):
//   exactly one response per request, in order: o_rdata for reads (zero
//   otherwise), o_tx_valid/o_tx_byte for a transmitted byte, o_rx_dropped
//   when a host byte hit a full FIFO.
//   Response: held in the response register, or in the skid slot while
//   a response waits. Throughput: one request per cycle while the skid
//   slot is empty; every request is handled in one pass of flag and pointer
//   logic. The FIFO keeps the two oldest bytes in registered read ports,
//   re-addressed every cycle from the next tail: a data read may drain twice.
//   Stall: the response register plus a skid slot let one more request in
//   while a response waits; o_ready drops only when both slots are full.
//   Reset (synchronous, active low): UART registers and FIFO pointers clear,
//   response slots empty. FIFO contents are not cleared; only written
//   entries are ever delivered.
`default_nettype none

module usart_regs_with_rx_fifo (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [9:0]  i_offset,
    input  wire logic [31:0] i_wdata,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_rdata,
    output logic             o_tx_valid,
    output logic [7:0]       o_tx_byte,
    output logic             o_rx_dropped
);

    // Architectural state
    logic [31:0] r_status, n_status;
    logic [7:0]  r_data,   n_data;
    logic [31:0] r_baud,   n_baud;
    logic [31:0] r_ctrl1,  n_ctrl1;
    logic [31:0] r_ctrl2,  n_ctrl2;
    logic [31:0] r_ctrl3,  n_ctrl3;
    logic [usart_pkg::PTR_W-1:0] r_head, n_head;
    logic [usart_pkg::PTR_W-1:0] r_tail, n_tail;
    logic [usart_pkg::CNT_W-1:0] r_count, n_count;

    // FIFO memory and its two registered read ports (tail, tail+1)
    logic [7:0] mem [usart_pkg::FIFO_DEPTH];
    logic [7:0] r_rd0, r_rd1;
    logic [usart_pkg::PTR_W-1:0] raddr0, raddr1;
    logic [usart_pkg::PTR_W-1:0] tail_p1, tail_p2;
    logic       push;
    logic [1:0] pops;
    logic       mem_we;

    // Response slots
    usart_pkg::t_result res;
    usart_pkg::t_result r_out, n_out;
    usart_pkg::t_result r_skid, n_skid;
    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;

    logic in_fire, out_fire;
    logic rx_en;

    assign o_ready  = !r_skid_valid;
    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_out_valid && i_ready;

    assign rx_en = r_ctrl1[usart_pkg::C1_UE] && r_ctrl1[usart_pkg::C1_RE];

    // Per-request register and FIFO update
    always_comb begin
        n_status = r_status;
        n_data   = r_data;
        n_baud   = r_baud;
        n_ctrl1  = r_ctrl1;
        n_ctrl2  = r_ctrl2;
        n_ctrl3  = r_ctrl3;
        push     = 1'b0;
        pops     = 2'd0;
        res      = '0;

        unique case (i_cmd)
            usart_pkg::CMD_READ: begin
                // drain ahead of the register read
                if (rx_en && !r_status[usart_pkg::ST_RXNE] && r_count != '0) begin
                    n_data = r_rd0;
                    n_status[usart_pkg::ST_RXNE] = 1'b1;
                    pops = 2'd1;
                end
                unique case (i_offset)
                    usart_pkg::OFF_SR:  res.rdata = n_status;
                    usart_pkg::OFF_DR: begin
                        res.rdata = {24'd0, n_data};
                        n_status[usart_pkg::ST_RXNE] = 1'b0;
                        n_data = 8'd0;
                        // refill; second pop comes from the tail+1 port
                        if (rx_en && r_count > usart_pkg::CNT_W'(pops)) begin
                            n_data = (pops != 2'd0) ? r_rd1 : r_rd0;
                            n_status[usart_pkg::ST_RXNE] = 1'b1;
                            pops = pops + 2'd1;
                        end
                    end
                    usart_pkg::OFF_BRR: res.rdata = r_baud;
                    usart_pkg::OFF_CR1: res.rdata = r_ctrl1;
                    usart_pkg::OFF_CR2: res.rdata = r_ctrl2;
                    usart_pkg::OFF_CR3: res.rdata = r_ctrl3;
                    default:            res.rdata = 32'd0;
                endcase
            end
            usart_pkg::CMD_WRITE: begin
                unique case (i_offset)
                    usart_pkg::OFF_SR: n_status = i_wdata;
                    usart_pkg::OFF_DR: begin
                        n_data = i_wdata[7:0];
                        if (r_ctrl1[usart_pkg::C1_UE] && r_ctrl1[usart_pkg::C1_TE]) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = i_wdata[7:0];
                        end
                        n_status[usart_pkg::ST_TXE] = 1'b1;
                        n_status[usart_pkg::ST_TC]  = 1'b1;
                    end
                    usart_pkg::OFF_BRR: n_baud = i_wdata;
                    usart_pkg::OFF_CR1: begin
                        n_ctrl1 = i_wdata;
                        if (i_wdata[usart_pkg::C1_UE] && i_wdata[usart_pkg::C1_RE]
                            && !r_status[usart_pkg::ST_RXNE] && r_count != '0) begin
                            n_data = r_rd0;
                            n_status[usart_pkg::ST_RXNE] = 1'b1;
                            pops = 2'd1;
                        end
                    end
                    usart_pkg::OFF_CR2: n_ctrl2 = i_wdata;
                    usart_pkg::OFF_CR3: n_ctrl3 = i_wdata;
                    default: ;
                endcase
            end
            usart_pkg::CMD_HOST: begin
                if (r_count == usart_pkg::CNT_W'(usart_pkg::FIFO_DEPTH)) begin
                    res.rx_dropped = 1'b1;
                end else begin
                    push = 1'b1;
                end
                // empty FIFO: the new byte goes straight to the data register
                if (rx_en && !r_status[usart_pkg::ST_RXNE] && (r_count != '0 || push)) begin
                    n_data = (r_count != '0) ? r_rd0 : i_rx_byte;
                    n_status[usart_pkg::ST_RXNE] = 1'b1;
                    pops = 2'd1;
                end
            end
            usart_pkg::CMD_TICK: begin
                if (rx_en && !r_status[usart_pkg::ST_RXNE] && r_count != '0) begin
                    n_data = r_rd0;
                    n_status[usart_pkg::ST_RXNE] = 1'b1;
                    pops = 2'd1;
                end
            end
        endcase
    end

    // Pointer arithmetic
    assign tail_p1 = usart_pkg::ptr_inc(r_tail);
    assign tail_p2 = usart_pkg::ptr_inc(tail_p1);

    always_comb begin
        case (pops)
            2'd0:    n_tail = r_tail;
            2'd1:    n_tail = tail_p1;
            default: n_tail = tail_p2;
        endcase
    end

    assign n_head  = push ? usart_pkg::ptr_inc(r_head) : r_head;
    assign n_count = r_count + usart_pkg::CNT_W'(push) - usart_pkg::CNT_W'(pops);

    // Read ports track the tail that will stand after this cycle
    assign mem_we = in_fire && push;
    assign raddr0 = in_fire ? n_tail : r_tail;
    assign raddr1 = usart_pkg::ptr_inc(raddr0);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_head] <= i_rx_byte;
        end
        // write-first bypass: a byte pushed this cycle is seen next cycle
        r_rd0 <= (mem_we && r_head == raddr0) ? i_rx_byte : mem[raddr0];
        r_rd1 <= (mem_we && r_head == raddr1) ? i_rx_byte : mem[raddr1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
            r_data   <= '0;
            r_baud   <= '0;
            r_ctrl1  <= '0;
            r_ctrl2  <= '0;
            r_ctrl3  <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
        end else if (in_fire) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_baud   <= n_baud;
            r_ctrl1  <= n_ctrl1;
            r_ctrl2  <= n_ctrl2;
            r_ctrl3  <= n_ctrl3;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
        end
    end

    // Response register plus skid slot
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid      = r_out_valid;
    assign o_rdata      = r_out.rdata;
    assign o_tx_valid   = r_out.tx_valid;
    assign o_tx_byte    = r_out.tx_byte;
    assign o_rx_dropped = r_out.rx_dropped;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= usart_pkg::CNT_W'(usart_pkg::FIFO_DEPTH))
        else $error("rx fifo count beyond depth");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a response while output slot is empty");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> ($stable(r_count) && $stable(r_status) && $stable(r_tail)))
        else $error("state changed without an accepted request");

    a_rxne_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_status[usart_pkg::ST_RXNE]) && $past(in_fire)
         && ($past(i_cmd) == usart_pkg::CMD_READ || $past(i_cmd) == usart_pkg::CMD_TICK))
        |-> (r_count < $past(r_count)))
        else $error("RXNE set without a byte leaving the fifo");

endmodule

`default_nettype wire
